// File: sv/ffba_pkg.sv
// Shared types and codes of the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator; depends on nothing.
`default_nettype none

package ffba_pkg;

  localparam int OFS_W = 16;  // offsets, sizes and block fields

  // operation codes of an input item
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // commands broadcast along the cell row
  localparam logic [2:0] CMD_HOLD  = 3'd0;
  localparam logic [2:0] CMD_SETUP = 3'd1;  // cell 0 takes the whole pool
  localparam logic [2:0] CMD_GRANT = 3'd2;  // mark block allocated
  localparam logic [2:0] CMD_SPLIT = 3'd3;  // allocate head, insert rest after it
  localparam logic [2:0] CMD_MARK  = 3'd4;  // mark block free
  localparam logic [2:0] CMD_MERGE = 3'd5;  // mark free, absorb right neighbor

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] bytes;
    logic             free;
  } entry_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [OFS_W-1:0] arg;   // request size, or payload bytes on setup
  } cmd_t;

  typedef struct packed {
    logic [OFS_W-1:0] req;
    logic [OFS_W-1:0] off;
  } query_t;

  typedef struct packed {
    logic live;  // entry lies below the block count
    logic fit;   // free and large enough for the request
    logic big;   // payload exceeds request plus one header
    logic hit;   // allocated block whose payload sits at the free offset
  } flags_t;

endpackage

`default_nettype wire

// File: sv/ffba_cell.sv
// One table entry of the allocator: holds a block and shifts with its neighbors.
// Depends on ffba_pkg.
`default_nettype none

module ffba_cell #(
  parameter int IDX          = 0,
  parameter int HEADER_BYTES = 32,
  parameter int IW           = 6,
  parameter int CW           = 7
) (
  input  wire logic            clk,
  input  wire ffba_pkg::cmd_t  cmd,
  input  wire logic [IW-1:0]   pos,
  input  wire logic [CW-1:0]   count,
  input  wire ffba_pkg::query_t query,
  input  wire ffba_pkg::entry_t left,
  input  wire ffba_pkg::entry_t right,
  output ffba_pkg::entry_t     ent,
  output ffba_pkg::flags_t     flags
);

  localparam logic [16:0] HDR  = 17'(HEADER_BYTES);
  localparam int          PREV = (IDX > 0) ? IDX - 1 : 0;

  ffba_pkg::entry_t ent_next;
  logic             at_pos;
  logic             after_pos;
  logic             beyond_pos;
  logic [16:0]      split_start;
  logic [16:0]      split_bytes;
  logic [16:0]      merged_bytes;

  assign at_pos     = (IW'(IDX) == pos);
  assign after_pos  = (IDX > 0) && (IW'(PREV) == pos);
  assign beyond_pos = (IW'(IDX) > pos);

  assign split_start  = {1'b0, left.start} + HDR + {1'b0, cmd.arg};
  assign split_bytes  = {1'b0, left.bytes} - {1'b0, cmd.arg} - HDR;
  assign merged_bytes = {1'b0, ent.bytes} + {1'b0, right.bytes} + HDR;

  always_comb begin
    ent_next = ent;
    case (cmd.kind)
      ffba_pkg::CMD_SETUP: begin
        if (IDX == 0) begin
          ent_next.start = '0;
          ent_next.bytes = cmd.arg;
          ent_next.free  = 1'b1;
        end
      end
      ffba_pkg::CMD_GRANT: begin
        if (at_pos) ent_next.free = 1'b0;
      end
      ffba_pkg::CMD_SPLIT: begin
        if (at_pos) begin
          ent_next.bytes = cmd.arg;
          ent_next.free  = 1'b0;
        end else if (after_pos) begin
          ent_next.start = split_start[15:0];
          ent_next.bytes = split_bytes[15:0];
          ent_next.free  = 1'b1;
        end else if (beyond_pos) begin
          ent_next = left;  // shift up to open a slot
        end
      end
      ffba_pkg::CMD_MARK: begin
        if (at_pos) ent_next.free = 1'b1;
      end
      ffba_pkg::CMD_MERGE: begin
        if (at_pos) begin
          ent_next.bytes = merged_bytes[15:0];
          ent_next.free  = 1'b1;
        end else if (beyond_pos) begin
          ent_next = right;  // shift down over the absorbed block
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  always_comb begin
    flags.live = (CW'(IDX) < count);
    flags.fit  = flags.live && ent.free && (ent.bytes >= query.req);
    flags.big  = ({1'b0, ent.bytes} > ({1'b0, query.req} + HDR));
    flags.hit  = flags.live && !ent.free && (({1'b0, ent.start} + HDR) == {1'b0, query.off});
  end

endmodule

`default_nettype wire

// File: sv/ffba_pick.sv
// Priority pick over the cell row: lowest set request bit, one-hot and encoded.
// Depends on nothing.
`default_nettype none

module ffba_pick #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  wire logic [N-1:0]  cand,
  output logic      [N-1:0]  first,
  output logic      [IW-1:0] index,
  output logic               found
);

  assign first = cand & (~cand + N'(1));
  assign found = |cand;

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) index = index | IW'(i);
    end
  end

endmodule

`default_nettype wire

// File: sv/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: control, cell row and result register.
// Depends on ffba_pkg, ffba_cell and ffba_pick.
//
// Usage:
//   cfg channel  : cfg_valid/cfg_ready/cfg_data write the pool size. Each write
//                  sets the pool up again as one free block (none if the size is
//                  at most one header). cfg_ready is high only while idle.
//   s channel    : one item per request; s_tuser selects allocate or free,
//                  s_tdata carries request size and free offset.
//   m channel    : one result item per request: status and granted payload offset.
// Timing:
//   An accepted item is matched against every cell in the cycle after
//   acceptance; the lowest matching cell wins. The result is loaded into the
//   output register once the output slot is free. A request that changes the
//   table then shifts the cell row in the update state (in a second pass too
//   when a free merges with blocks on both sides); the next item is accepted
//   during the last update pass.
// Reset: clears the block count (no pool) and the control state; allocate and
//   free then answer "failed" until the pool size is written.
// Stall: while m_tready is low the finished result holds in the output register
//   and the next item is still accepted; its search holds until the slot frees.
`default_nettype none

module first_fit_block_allocator #(
  parameter longint POOL_BYTES   = 65536,
  parameter int     HEADER_BYTES = 32,
  parameter int     MAX_BLOCKS   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write: pool size
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,
  // requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] request_size, [31:16] free_offset
  input  wire logic [0:0]  s_tuser,   // [0] operation
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [1:0] status, [17:2] payload_offset, rest zero
);

  localparam int N  = MAX_BLOCKS;
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [16:0] HDR      = 17'(HEADER_BYTES);
  localparam logic [16:0] POOL_CAP = (POOL_BYTES < 65536) ? 17'(POOL_BYTES) : 17'd65536;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  // control and payload registers
  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          q_op;
  logic [15:0]   q_req;
  logic [15:0]   q_off;
  logic [2:0]    cmd_kind;
  logic [IW-1:0] cmd_pos;
  logic          cmd_again;
  logic [1:0]    out_status;
  logic [15:0]   out_offset;

  // handshakes
  logic in_acc;
  logic cfg_acc;
  logic slot_free;
  logic last_upd;

  // cell row
  ffba_pkg::entry_t ent [N];
  ffba_pkg::flags_t flg [N];
  ffba_pkg::cmd_t   cell_cmd;
  ffba_pkg::query_t query;
  logic [N-1:0]     fit_vec, big_vec, hit_vec, free_vec, live_vec;

  // search results
  logic [N-1:0]  cand;
  logic [N-1:0]  sel;
  logic [IW-1:0] sel_idx;
  logic          found;
  logic [15:0]   sel_start;
  logic [16:0]   grant_sum;
  logic          split_ok;
  logic          merge_l;
  logic          merge_r;
  logic [1:0]    res_status;
  logic [15:0]   res_offset;
  logic          upd_needed;
  logic [2:0]    upd_kind;
  logic [IW-1:0] upd_pos;
  logic          upd_again;

  // pool setup
  logic [16:0] eff_pool;
  logic [16:0] setup_bytes;

  assign slot_free = !m_tvalid || m_tready;
  assign last_upd  = (state == S_UPDATE) && !cmd_again;
  assign s_tready  = (state == S_IDLE) || last_upd;
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign m_tdata = {6'd0, out_offset, out_status};

  assign query.req = q_req;
  assign query.off = q_off;

  // clamp the written size to the pool limit
  assign eff_pool    = (cfg_data > POOL_CAP) ? POOL_CAP : cfg_data;
  assign setup_bytes = eff_pool - HDR;

  always_comb begin
    cell_cmd.kind = ffba_pkg::CMD_HOLD;
    cell_cmd.arg  = q_req;
    if (cfg_acc) begin
      cell_cmd.kind = ffba_pkg::CMD_SETUP;
      cell_cmd.arg  = setup_bytes[15:0];
    end else if (state == S_UPDATE) begin
      cell_cmd.kind = cmd_kind;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffba_pkg::entry_t left_ent;
    ffba_pkg::entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
    end

    ffba_cell #(
      .IDX          (i),
      .HEADER_BYTES (HEADER_BYTES),
      .IW           (IW),
      .CW           (CW)
    ) u_cell (
      .clk   (clk),
      .cmd   (cell_cmd),
      .pos   (cmd_pos),
      .count (count),
      .query (query),
      .left  (left_ent),
      .right (right_ent),
      .ent   (ent[i]),
      .flags (flg[i])
    );

    assign fit_vec[i]  = flg[i].fit;
    assign big_vec[i]  = flg[i].big;
    assign hit_vec[i]  = flg[i].hit;
    assign live_vec[i] = flg[i].live;
    assign free_vec[i] = ent[i].free;
  end

  // first fit on allocate, the matching allocated block on free
  assign cand = (q_op == ffba_pkg::OP_FREE) ? hit_vec : fit_vec;

  ffba_pick #(
    .N  (N),
    .IW (IW)
  ) u_pick (
    .cand  (cand),
    .first (sel),
    .index (sel_idx),
    .found (found)
  );

  always_comb begin
    sel_start = '0;
    for (int i = 0; i < N; i++) begin
      if (sel[i]) sel_start = sel_start | ent[i].start;
    end
  end

  assign grant_sum = {1'b0, sel_start} + HDR;
  assign split_ok  = (|(sel & big_vec)) && (count < CW'(MAX_BLOCKS));
  // neighbor below is always live; the one above must lie inside the table
  assign merge_l   = |(sel & {free_vec[N-2:0], 1'b0});
  assign merge_r   = |(sel & {1'b0, free_vec[N-1:1] & live_vec[N-1:1]});

  always_comb begin
    res_status = ffba_pkg::ST_FAIL;
    res_offset = '0;
    upd_needed = 1'b0;
    upd_kind   = ffba_pkg::CMD_HOLD;
    upd_pos    = sel_idx;
    upd_again  = 1'b0;
    if (count != '0) begin
      if (q_op == ffba_pkg::OP_ALLOC) begin
        if ((q_req != '0) && found) begin
          res_status = ffba_pkg::ST_OK;
          res_offset = grant_sum[15:0];
          upd_needed = 1'b1;
          upd_kind   = split_ok ? ffba_pkg::CMD_SPLIT : ffba_pkg::CMD_GRANT;
        end
      end else if (!found) begin
        res_status = ffba_pkg::ST_BADFREE;
      end else begin
        res_status = ffba_pkg::ST_OK;
        upd_needed = 1'b1;
        if (!merge_l && !merge_r) begin
          upd_kind = ffba_pkg::CMD_MARK;
        end else begin
          // merging into the left neighbor works from its slot; a second pass
          // at the same slot then absorbs the right neighbor
          upd_kind  = ffba_pkg::CMD_MERGE;
          upd_pos   = merge_l ? (sel_idx - IW'(1)) : sel_idx;
          upd_again = merge_l && merge_r;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (slot_free) state_next = upd_needed ? S_UPDATE : S_IDLE;
      end
      S_UPDATE: begin
        if (!cmd_again) state_next = in_acc ? S_SEARCH : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    if (cfg_acc) begin
      count_next = (eff_pool > HDR) ? CW'(1) : '0;
    end else if (state == S_UPDATE) begin
      if (cmd_kind == ffba_pkg::CMD_SPLIT) count_next = count + CW'(1);
      else if (cmd_kind == ffba_pkg::CMD_MERGE) count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((state == S_SEARCH) && slot_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // latch the item, the result and the pending table command
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_op  <= s_tuser[0];
      q_req <= s_tdata[15:0];
      q_off <= s_tdata[31:16];
    end
    if ((state == S_SEARCH) && slot_free) begin
      out_status <= res_status;
      out_offset <= res_offset;
      cmd_kind   <= upd_kind;
      cmd_pos    <= upd_pos;
      cmd_again  <= upd_again;
    end else if (state == S_UPDATE) begin
      cmd_again <= 1'b0;
    end
  end

  // the table never grows beyond its cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  // a request that fails or is rejected leaves the table alone
  a_fail_keeps_table: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEARCH) && slot_free && !upd_needed) |=> (count == $past(count)))
    else $error("table changed on a failed request");

  // a split adds exactly one block
  a_split_grows: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UPDATE) && (cmd_kind == ffba_pkg::CMD_SPLIT)) |=>
      (count == $past(count) + CW'(1)))
    else $error("split did not add one block");

  // only a successful grant carries an offset
  a_offset_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != ffba_pkg::ST_OK)) |-> (out_offset == '0))
    else $error("offset on a failed result");

endmodule

`default_nettype wire
